// File: rtl/core/mlq_pkg.sv
// Shared sizes, codes and controller/datapath handshake types for the multi-level queue.
package mlq_pkg;

  localparam int NUM_LEVELS = 4;
  localparam int DEPTH      = 4;
  localparam int DATA_WIDTH = 32;

  localparam int CMD_W    = 2;
  localparam int LEVEL_W  = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MEM_DEPTH = NUM_LEVELS * DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_LIST    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    write;
    logic    read_next;
    logic    pop;
    logic    emit;
    status_t emit_status;
    logic    use_data;
    logic    emit_last;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic lvl_ok;
    logic no_data;
    logic full;
    logic at_rear;
  } dp_stat_t;

endpackage

// File: rtl/core/mlq_ctrl.sv
// Sequencer for the multi-level queue: decodes a transaction and steps the datapath.
module mlq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mlq_pkg::dp_stat_t  stat,
  output mlq_pkg::ctrl_cmd_t ctl
);

  mlq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    ctl             = '0;
    ctl.emit_status = mlq_pkg::ST_OK;
    busy            = 1'b1;
    case (state_r)
      mlq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = mlq_pkg::S_EXEC;
        end
      end
      mlq_pkg::S_EXEC: begin
        if (stat.cmd == mlq_pkg::CMD_ENQUEUE) begin
          ctl.emit      = 1'b1;
          ctl.emit_last = 1'b1;
          if (!stat.lvl_ok || stat.full) begin
            ctl.emit_status = mlq_pkg::ST_OVERFLOW;
          end else begin
            ctl.write = 1'b1;
          end
          state_nxt = mlq_pkg::S_IDLE;
        end else if (!stat.lvl_ok || stat.no_data) begin
          ctl.emit        = 1'b1;
          ctl.emit_last   = 1'b1;
          ctl.emit_status = mlq_pkg::ST_UNDERFLOW;
          state_nxt       = mlq_pkg::S_IDLE;
        end else begin
          // front slot is being read this cycle
          state_nxt = mlq_pkg::S_READ;
        end
      end
      mlq_pkg::S_READ: begin
        ctl.emit     = 1'b1;
        ctl.use_data = 1'b1;
        state_nxt    = mlq_pkg::S_IDLE;
        case (stat.cmd)
          mlq_pkg::CMD_DEQUEUE: begin
            ctl.pop       = 1'b1;
            ctl.emit_last = 1'b1;
          end
          mlq_pkg::CMD_LIST: begin
            ctl.emit_last = stat.at_rear;
            if (!stat.at_rear) begin
              ctl.read_next = 1'b1;
              state_nxt     = mlq_pkg::S_READ;
            end
          end
          default: begin
            ctl.emit_last = 1'b1;
          end
        endcase
      end
      default: begin
        state_nxt = mlq_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_single_cycle_cmds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mlq_pkg::S_READ && stat.cmd != mlq_pkg::CMD_LIST) |=>
      (state_r == mlq_pkg::S_IDLE))
    else $error("dequeue/peek held the sequencer past one result");
  a_list_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && !ctl.emit_last) |=> (state_r == mlq_pkg::S_READ))
    else $error("list stopped before its final element");
`endif

endmodule

// File: rtl/core/mlq_datapath.sv
// Queue storage, per-level front/rear pointers and the registered result stage.
module mlq_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mlq_pkg::CMD_W-1:0]           in_command,
  input  logic [mlq_pkg::LEVEL_W-1:0]         in_level,
  input  logic signed [mlq_pkg::VALUE_W-1:0]  in_value,
  input  mlq_pkg::ctrl_cmd_t                  ctl,
  output mlq_pkg::dp_stat_t                   stat,
  output logic                                out_valid,
  output logic [mlq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [mlq_pkg::VALUE_W-1:0]  out_result_value,
  output logic                                out_last
);

  localparam int SLOT_W = mlq_pkg::SLOT_W;
  localparam int LIDX_W = mlq_pkg::LVL_IDX_W;
  localparam int ADDR_W = mlq_pkg::ADDR_W;
  localparam int DW     = mlq_pkg::DATA_WIDTH;

  // latched transaction
  mlq_pkg::cmd_t                       item_cmd_r;
  logic [mlq_pkg::LEVEL_W-1:0]         item_level_r;
  logic signed [mlq_pkg::VALUE_W-1:0]  item_value_r;

  logic [SLOT_W-1:0] front_r [mlq_pkg::NUM_LEVELS];
  logic [SLOT_W-1:0] rear_r  [mlq_pkg::NUM_LEVELS];
  logic [mlq_pkg::NUM_LEVELS-1:0] lvl_empty_r;

  logic [SLOT_W-1:0] idx_r;

  logic signed [DW-1:0] mem [mlq_pkg::MEM_DEPTH];
  logic signed [DW-1:0] rd_data_r;

  logic                         out_valid_r;
  logic [mlq_pkg::STATUS_W-1:0] out_status_r;
  logic signed [mlq_pkg::VALUE_W-1:0] out_value_r;
  logic                         out_last_r;

  logic [LIDX_W-1:0] lvl_idx;
  logic              lvl_ok;
  logic [SLOT_W-1:0] front_sel, rear_sel, wr_slot, rd_slot;
  logic              empty_sel;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [LIDX_W-1:0] lvl,
                                                  logic [SLOT_W-1:0] slot);
    return ADDR_W'(lvl) * ADDR_W'(mlq_pkg::DEPTH) + ADDR_W'(slot);
  endfunction

  assign lvl_idx   = LIDX_W'(item_level_r);
  assign lvl_ok    = (32'(item_level_r) < mlq_pkg::NUM_LEVELS);
  assign front_sel = front_r[lvl_idx];
  assign rear_sel  = rear_r[lvl_idx];
  assign empty_sel = lvl_empty_r[lvl_idx];

  assign wr_slot = empty_sel ? '0 : rear_sel + SLOT_W'(1);
  assign rd_slot = ctl.read_next ? idx_r + SLOT_W'(1) : front_sel;
  assign wr_addr = slot_addr(lvl_idx, wr_slot);
  assign rd_addr = slot_addr(lvl_idx, rd_slot);

  assign stat.cmd     = item_cmd_r;
  assign stat.lvl_ok  = lvl_ok;
  assign stat.no_data = empty_sel || (front_sel > rear_sel);
  assign stat.full    = !empty_sel && (rear_sel == SLOT_W'(mlq_pkg::DEPTH - 1));
  assign stat.at_rear = (idx_r == rear_sel);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_cmd_r   <= mlq_pkg::cmd_t'(in_command);
      item_level_r <= in_level;
      item_value_r <= in_value;
    end
    idx_r <= ctl.read_next ? idx_r + SLOT_W'(1) : front_sel;
  end

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      mem[wr_addr] <= DW'(item_value_r);
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mlq_pkg::NUM_LEVELS; i++) begin
        front_r[i] <= '0;
        rear_r[i]  <= '0;
      end
      lvl_empty_r <= '1;
    end else if (ctl.write) begin
      if (empty_sel) begin
        front_r[lvl_idx]     <= '0;
        lvl_empty_r[lvl_idx] <= 1'b0;
      end
      rear_r[lvl_idx] <= wr_slot;
    end else if (ctl.pop) begin
      if (front_sel == rear_sel) begin
        // last element gone: level restarts from slot zero
        front_r[lvl_idx]     <= '0;
        rear_r[lvl_idx]      <= '0;
        lvl_empty_r[lvl_idx] <= 1'b1;
      end else begin
        front_r[lvl_idx] <= front_sel + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status_r <= ctl.emit_status;
      out_value_r  <= ctl.use_data ? mlq_pkg::VALUE_W'(rd_data_r) : '0;
      out_last_r   <= ctl.emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_last         = out_last_r;

`ifndef NO_ASSERTIONS
  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.write |-> (lvl_ok && !stat.full))
    else $error("enqueue written into a full or invalid level");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> (lvl_ok && !stat.no_data))
    else $error("dequeue from an empty level");
  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != mlq_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("error result carries a nonzero value");
  for (genvar g = 0; g < mlq_pkg::NUM_LEVELS; g++) begin : g_ptr_chk
    a_front_le_rear: assert property (@(posedge clk) disable iff (!rst_n)
      !lvl_empty_r[g] |-> (front_r[g] <= rear_r[g]))
      else $error("front pointer passed rear pointer");
  end
`endif

endmodule

// File: rtl/core/multi_level_linear_queue.sv
// Enqueue, overflow and underflow results are emitted from the execute state; dequeue and
// peek from the read state, after the registered read of the queue store; a list of n
// elements gives one result per cycle there; all pass the registered result stage.
// A new transaction is taken only when the sequencer is back in idle (busy low).
// Synchronous active-low reset empties every level; queue data is not cleared.
// Results are one-cycle strobes on out_valid; the receiver cannot stall.
module multi_level_linear_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mlq_pkg::CMD_W-1:0]           in_command,
  input  logic [mlq_pkg::LEVEL_W-1:0]         in_level,
  input  logic signed [mlq_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  output logic [mlq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [mlq_pkg::VALUE_W-1:0]  out_result_value,
  output logic                                out_last
);

  mlq_pkg::ctrl_cmd_t ctl;
  mlq_pkg::dp_stat_t  stat;

  mlq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  mlq_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_level         (in_level),
    .in_value         (in_value),
    .ctl              (ctl),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_last         (out_last)
  );

endmodule

// File: tb/sv/mlq_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the multi-level linear queue: tracks each level and checks every strobe.
module mlq_result_checker
  import mlq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [LEVEL_W-1:0]         in_level,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic                       out_valid,
  input  logic [STATUS_W-1:0]        out_status,
  input  logic signed [VALUE_W-1:0]  out_result_value,
  input  logic                       out_last,
  output int                         mismatch_count,
  output int                         pending
);

  typedef struct {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic                 last;
  } queue_result_t;

  queue_result_t          awaited_results[$];
  logic [DATA_WIDTH-1:0]  slot_data [NUM_LEVELS][DEPTH];
  int unsigned            head_slot [NUM_LEVELS];
  int unsigned            tail_slot [NUM_LEVELS];
  bit                     level_empty [NUM_LEVELS];

  task automatic report_mismatch(string what);
    $display("%0t ns  mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void add_result(status_t status, logic [VALUE_W-1:0] value, logic last);
    awaited_results.push_back('{status, value, last});
  endfunction

  // Apply one command to the tracked queues and queue up the responses it must produce.
  function automatic void apply_queue_command(cmd_t cmd, int lvl, logic [VALUE_W-1:0] value);
    int unsigned f;
    int unsigned r;
    if (lvl >= NUM_LEVELS) begin
      add_result(cmd == CMD_ENQUEUE ? ST_OVERFLOW : ST_UNDERFLOW, '0, 1'b1);
      return;
    end
    f = head_slot[lvl];
    r = tail_slot[lvl];
    if (cmd == CMD_ENQUEUE) begin
      // linear queue: full once rear hits the last slot, freed front slots don't count
      if (!level_empty[lvl] && r >= DEPTH - 1) begin
        add_result(ST_OVERFLOW, '0, 1'b1);
        return;
      end
      if (level_empty[lvl]) begin
        head_slot[lvl]   = 0;
        r                = 0;
        level_empty[lvl] = 1'b0;
      end else begin
        r = r + 1;
      end
      tail_slot[lvl]    = r;
      slot_data[lvl][r] = value[DATA_WIDTH-1:0];
      add_result(ST_OK, '0, 1'b1);
      return;
    end
    if (level_empty[lvl]) begin
      add_result(ST_UNDERFLOW, '0, 1'b1);
      return;
    end
    case (cmd)
      CMD_DEQUEUE: begin
        add_result(ST_OK, VALUE_W'($signed(slot_data[lvl][f])), 1'b1);
        if (f == r) begin
          head_slot[lvl]   = 0;
          tail_slot[lvl]   = 0;
          level_empty[lvl] = 1'b1;
        end else begin
          head_slot[lvl] = f + 1;
        end
      end
      CMD_PEEK: begin
        add_result(ST_OK, VALUE_W'($signed(slot_data[lvl][f])), 1'b1);
      end
      default: begin
        for (int unsigned i = f; i <= r; i++)
          add_result(ST_OK, VALUE_W'($signed(slot_data[lvl][i])), i == r);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_slot[i]   = 0;
        tail_slot[i]   = 0;
        level_empty[i] = 1'b1;
      end
      awaited_results.delete();
      mismatch_count = 0;
    end else begin
      // results of earlier transactions go first, then the one taken at this edge
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d value=%h last=%b",
                                    out_status, out_result_value, out_last));
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_result_value !== want.value)
            report_mismatch($sformatf("value %h, want %h", out_result_value, want.value));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_last, want.last));
        end
      end
      if (start && !busy)
        apply_queue_command(cmd_t'(in_command), int'(in_level), in_value);
    end
    pending <= awaited_results.size();
  end

endmodule

// File: tb/sv/multi_level_linear_queue_test.sv
`timescale 1ns / 100ps
// Top of the multi-level linear queue testbench: clock, reset, command stimulus and verdict.
module multi_level_linear_queue_test;
  import mlq_pkg::*;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [CMD_W-1:0]           in_command;
  logic [LEVEL_W-1:0]         in_level;
  logic signed [VALUE_W-1:0]  in_value;
  logic                       out_valid;
  logic [STATUS_W-1:0]        out_status;
  logic signed [VALUE_W-1:0]  out_result_value;
  logic                       out_last;

  int mismatch_count;
  int pending;
  int idle_pct;
  int drain_wait;
  int idle_pct_list [3] = '{0, 54, 38};

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  multi_level_linear_queue DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_level         (in_level),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_last         (out_last)
  );

  mlq_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_level         (in_level),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_last         (out_last),
    .mismatch_count   (mismatch_count),
    .pending          (pending)
  );

  // One transaction: optional idle cycles, then hold start until the block takes it.
  task automatic issue(cmd_t cmd, logic [LEVEL_W-1:0] lvl, logic signed [VALUE_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_level   <= lvl;
    in_value   <= value;
    do @(posedge clk); while (busy);
  endtask

  // Enqueue-heavy mix so levels fill up, overflow and drain back to empty.
  task automatic random_item();
    int unsigned pick;
    int unsigned vsel;
    cmd_t        cmd;
    logic [VALUE_W-1:0] value;
    pick = $urandom_range(99);
    if (pick < 40)
      cmd = CMD_ENQUEUE;
    else if (pick < 70)
      cmd = CMD_DEQUEUE;
    else if (pick < 85)
      cmd = CMD_PEEK;
    else
      cmd = CMD_LIST;
    vsel = $urandom_range(9);
    case (vsel)
      0:       value = 32'h7fff_ffff;
      1:       value = 32'h8000_0000;
      2:       value = '0;
      3:       value = '1;
      default: value = $urandom;
    endcase
    issue(cmd, LEVEL_W'($urandom_range(NUM_LEVELS - 1)), value);
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_ENQUEUE;
    in_level   = '0;
    in_value   = '0;
    idle_pct   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty level: every read-type command underflows
    issue(CMD_DEQUEUE, 2'd0, 32'h1234_5678);
    issue(CMD_PEEK,    2'd0, '0);
    issue(CMD_LIST,    2'd0, '0);
    // fill level 0 with extreme values, then overflow
    issue(CMD_ENQUEUE, 2'd0, 32'h7fff_ffff);
    issue(CMD_ENQUEUE, 2'd0, 32'h8000_0000);
    issue(CMD_ENQUEUE, 2'd0, 32'haaaa_aaaa);
    issue(CMD_ENQUEUE, 2'd0, 32'h5555_5555);
    issue(CMD_ENQUEUE, 2'd0, '1);
    issue(CMD_LIST,    2'd0, '0);
    issue(CMD_PEEK,    2'd0, '0);
    issue(CMD_DEQUEUE, 2'd0, '0);
    // still full after a dequeue: freed front slot is not reused
    issue(CMD_ENQUEUE, 2'd0, '0);
    issue(CMD_LIST,    2'd0, '0);
    issue(CMD_DEQUEUE, 2'd0, '0);
    issue(CMD_DEQUEUE, 2'd0, '0);
    issue(CMD_DEQUEUE, 2'd0, '0);
    issue(CMD_DEQUEUE, 2'd0, '0);
    // drained to empty, so enqueue works again
    issue(CMD_ENQUEUE, 2'd0, '0);
    // single-element list on the top level
    issue(CMD_ENQUEUE, 2'd3, '1);
    issue(CMD_LIST,    2'd3, '0);
    issue(CMD_DEQUEUE, 2'd3, '0);
    issue(CMD_ENQUEUE, 2'd1, 32'h0000_0001);
    issue(CMD_ENQUEUE, 2'd2, 32'hffff_fffe);

    foreach (idle_pct_list[p]) begin
      idle_pct = idle_pct_list[p];
      repeat (100) random_item();
    end

    start <= 1'b0;
    drain_wait = 0;
    do begin
      @(posedge clk);
      drain_wait++;
    end while (pending != 0 && drain_wait < 200);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
